>>> hw/rtl/olar_pkg.sv
// Shared types and constants for the ordered list block.
// Used by olar_out_stage and ordered_list_append_remove_at; no dependencies.
package olar_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 4;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    status_e                  status;
    logic                     last;
  } beat_t;

endpackage

>>> hw/rtl/olar_out_stage.sv
// Output register for result beats, with valid and stall handshake.
// Depends on olar_pkg for the beat type.
module olar_out_stage import olar_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  beat_t beat_i,
  output logic  can_load_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output beat_t beat_o
);

  logic  valid_q;
  beat_t beat_q;

  // The register can take a new beat when empty or when its beat leaves now.
  assign can_load_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i && can_load_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && can_load_o) begin
      beat_q <= beat_i;
    end
  end

  assign out_valid_o = valid_q;
  assign beat_o      = beat_q;

endmodule

>>> hw/rtl/ordered_list_append_remove_at.sv
// Bounded ordered list with append, remove at position and dump, built on one memory port pair.
// Append stores the entry when there is room and emits its beat; remove reads and captures
// the removed entry, moves each later entry one place over the registered read port and
// emits its beat; dump does one read and one beat per stored entry. One item at a time.
// Reset (rst_ni, asynchronous, active low) empties the list and the output register;
// the entry memory itself is not cleared, and only entries below the count are ever used.
module ordered_list_append_remove_at import olar_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               operation_i,
  input  logic signed [ValueW-1:0] value_i,
  input  logic [PosW-1:0]          position_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ValueW-1:0] entry_value_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  // Address width of the store, width of the fill count, and a width wide enough
  // to compare a position against the count.
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > PosW) ? CW : PosW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RM_CAP,
    S_SH_RD,
    S_SH_WR,
    S_RM_DONE,
    S_DP_RD,
    S_DP_EMIT
  } state_e;

  state_e                   state_q, state_d;
  logic [1:0]               op_q;
  logic signed [ValueW-1:0] val_q;
  logic [PosW-1:0]          pos_q;
  logic [CW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic signed [ValueW-1:0] removed_q, removed_d;

  // Entry store: one write port and one registered read port.
  logic signed [ValueW-1:0] mem_q [DEPTH];
  logic signed [ValueW-1:0] rdata_q;
  logic [AW-1:0]            raddr;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [ValueW-1:0] mem_wdata;

  // Beat toward the output register.
  logic  emit;
  beat_t emit_beat;
  logic  can_load;
  beat_t out_beat;

  logic [CW-1:0] idx_inc;
  logic          list_full;
  logic          list_empty;
  logic          pos_past_end;

  assign idx_inc      = idx_q + CW'(1);
  assign list_full    = (cnt_q == CW'(DEPTH));
  assign list_empty   = (cnt_q == '0);
  assign pos_past_end = (CMPW'(pos_q) >= CMPW'(cnt_q));

  // The block takes a new item only when the sequencer is idle.
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    removed_d = removed_q;
    raddr     = idx_q[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = cnt_q[AW-1:0];
    mem_wdata = val_q;
    emit      = 1'b0;
    emit_beat = '{value: '0, status: ST_OK, last: 1'b1};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          // The unused operation code is dropped without any beat.
          if (operation_i != OP_UNUSED) begin
            state_d = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        raddr = AW'(pos_q);
        case (op_q)
          OP_APPEND: begin
            emit_beat.status = list_full ? ST_FULL : ST_OK;
            if (can_load) begin
              emit = 1'b1;
              if (!list_full) begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + CW'(1);
              end
              state_d = S_IDLE;
            end
          end
          OP_REMOVE: begin
            if (list_empty || pos_past_end) begin
              emit_beat.status = list_empty ? ST_EMPTY : ST_RANGE;
              if (can_load) begin
                emit    = 1'b1;
                state_d = S_IDLE;
              end
            end else begin
              // Read the entry being removed; the move loop starts at its place.
              idx_d   = CW'(pos_q);
              state_d = S_RM_CAP;
            end
          end
          OP_DUMP: begin
            if (list_empty) begin
              emit_beat.status = ST_EMPTY;
              if (can_load) begin
                emit    = 1'b1;
                state_d = S_IDLE;
              end
            end else begin
              idx_d   = '0;
              state_d = S_DP_RD;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_RM_CAP: begin
        removed_d = rdata_q;
        state_d   = S_SH_RD;
      end

      // Each later entry moves one place toward the head: read at idx+1,
      // then write the read data at idx.
      S_SH_RD: begin
        if (idx_inc < cnt_q) begin
          raddr   = idx_inc[AW-1:0];
          state_d = S_SH_WR;
        end else begin
          state_d = S_RM_DONE;
        end
      end

      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        mem_wdata = rdata_q;
        idx_d     = idx_inc;
        state_d   = S_SH_RD;
      end

      S_RM_DONE: begin
        emit_beat.value = removed_q;
        if (can_load) begin
          emit    = 1'b1;
          cnt_d   = cnt_q - CW'(1);
          state_d = S_IDLE;
        end
      end

      S_DP_RD: begin
        state_d = S_DP_EMIT;
      end

      // The read address stays on idx, so the read data holds while the
      // output register is stalled.
      S_DP_EMIT: begin
        emit_beat.value = rdata_q;
        emit_beat.last  = (idx_inc == cnt_q);
        if (can_load) begin
          emit = 1'b1;
          if (idx_inc == cnt_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_inc;
            state_d = S_DP_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      op_q      <= OP_APPEND;
      val_q     <= '0;
      pos_q     <= '0;
      removed_q <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      removed_q <= removed_d;
      if (state_q == S_IDLE && in_valid_i) begin
        op_q  <= operation_i;
        val_q <= value_i;
        pos_q <= position_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  olar_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit),
    .beat_i      (emit_beat),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .beat_o      (out_beat)
  );

  assign entry_value_o = out_beat.value;
  assign status_o      = out_beat.status;
  assign last_o        = out_beat.last;

endmodule
